// File: hw/rtl/gbdt_pkg.sv
`timescale 1ns / 1ps
package gbdt_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_BFS   = 2'd2,
    OP_DFS   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [4:0] from_vertex;
    logic [4:0] to_vertex;
    logic       directed;
    logic [4:0] start_vertex;
  } in_item_t;

  typedef struct packed {
    logic [4:0] vertex;
    logic       last;
    logic [1:0] status;
  } out_item_t;

  localparam int unsigned CfgWidth = 6;

endpackage

// File: hw/rtl/graph_bfs_dfs_traversal.sv
`timescale 1ns / 1ps
// Adjacency-list graph store with breadth-first and depth-first traversal.
// Neighbor lists live in one synchronous memory (MAX_VERTICES rows of
// MAX_DEGREE slots rounded up to a power of two, registered read); a
// second synchronous memory holds the breadth queue or the depth stack,
// whichever the running traversal needs. Clear and a directed add edge go
// through S_ADD2 back to idle; an undirected add edge also passes S_DONE,
// where the second list is written. In a traversal each list entry costs
// a degree check, an adjacency read and a visited check, and each vertex a
// pop (queue read or stack restore) plus the degree check that ends its
// list. The latest visit is held back until the next one is found, so the
// final one can carry last. Results go through an output register, so the
// block stalls while the consumer holds ready low. The one register
// num_vertices is written through cfg_we_i/cfg_wdata_i; the user must write
// it only while the block is idle, which the block itself does not enforce.
// No clearing pass is needed after reset: degree counts and visited marks
// are flip-flops.
module graph_bfs_dfs_traversal
  import gbdt_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 32,
  parameter int unsigned MAX_DEGREE   = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o
);

  localparam int unsigned VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned DW = $clog2(MAX_DEGREE + 1);
  localparam int unsigned IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int unsigned AW = VW + IW;
  localparam int unsigned PW = $clog2(MAX_VERTICES + 1);
  // wide enough for any id, the register and the clamp value
  localparam int unsigned NW = ((VW > CfgWidth) ? VW : CfgWidth) + 1;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_ADD2  = 10'b0000000010,
    S_POP   = 10'b0000000100,
    S_POPRD = 10'b0000001000,
    S_NODE  = 10'b0000010000,
    S_NBRD  = 10'b0000100000,
    S_NBCHK = 10'b0001000000,
    S_EMIT  = 10'b0010000000,
    S_DONE  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [CfgWidth-1:0] nv_reg_q;
  logic [NW-1:0]       nv;
  logic [DW-1:0]       deg_q [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] vis_q;

  // memories
  logic [VW-1:0]  adj_mem [MAX_VERTICES*(1 << IW)];
  logic [VW+IW:0] wk_mem  [MAX_VERTICES];  // breadth queue or depth stack
  logic           adj_we;
  logic [AW-1:0]  adj_waddr, adj_raddr;
  logic [VW-1:0]  adj_wdata, adj_rdata_q;
  logic           wk_we;
  logic [VW-1:0]  wk_waddr, wk_raddr;
  logic [VW+IW:0] wk_wdata, wk_rdata_q;

  always_ff @(posedge clk_i) begin
    if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
    adj_rdata_q <= adj_mem[adj_raddr];
    if (wk_we) wk_mem[wk_waddr] <= wk_wdata;
    wk_rdata_q <= wk_mem[wk_raddr];
  end

  logic          dfs_q, dfs_d;
  logic [VW-1:0] node_q, node_d;
  logic [IW:0]   idx_q, idx_d;
  logic [PW-1:0] head_q, head_d, tail_q, tail_d;
  logic          emitted_q, emitted_d;
  logic          pend_q, pend_d;     // a visit waits for the output register
  logic [VW-1:0] pend_v_q, pend_v_d;
  logic          outv_q, outv_d;
  out_item_t     outd_q, outd_d;
  in_item_t      item_q, item_d;
  logic [MAX_VERTICES-1:0] vis_d;
  logic          deg_we0, deg_we1, deg_clr;
  logic [VW-1:0] deg_a0, deg_a1;
  logic [DW-1:0] deg_v0, deg_v1;

  always_comb begin
    if (nv_reg_q == '0) nv = NW'(1);
    else if (NW'(nv_reg_q) > NW'(MAX_VERTICES)) nv = NW'(MAX_VERTICES);
    else nv = NW'(nv_reg_q);
  end

  wire out_free = !outv_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE) && out_free;
  assign out_valid_o = outv_q;
  assign out_data_o  = outd_q;

  logic [VW-1:0] u, v, s;
  logic [DW:0]   du, dv;
  logic          range_bad, full_bad;
  logic [IW:0]   cur_deg;
  logic [VW-1:0] nb;
  logic          nb_new;
  logic [VW-1:0] wk_node;
  logic [IW:0]   wk_idx;

  always_comb begin
    u  = VW'(item_q.from_vertex);
    v  = VW'(item_q.to_vertex);
    s  = VW'(item_q.start_vertex);
    du = (DW+1)'(deg_q[u]);
    dv = (DW+1)'(deg_q[v]);
    range_bad = (NW'(item_q.from_vertex) >= nv) || (NW'(item_q.to_vertex) >= nv);
    if (!item_q.directed && u == v) full_bad = du + (DW+1)'(2) > (DW+1)'(MAX_DEGREE);
    else full_bad = (du + (DW+1)'(1) > (DW+1)'(MAX_DEGREE)) ||
                    (!item_q.directed && dv + (DW+1)'(1) > (DW+1)'(MAX_DEGREE));
    cur_deg = (IW+1)'(deg_q[node_q]);
    nb = adj_rdata_q;
    nb_new = (NW'(nb) < nv) && !vis_q[nb] && (tail_q < PW'(MAX_VERTICES));
    wk_node = wk_rdata_q[VW+IW:IW+1];
    wk_idx  = wk_rdata_q[IW:0];
  end

  always_comb begin
    state_d = state_q; dfs_d = dfs_q; node_d = node_q; idx_d = idx_q;
    head_d = head_q; tail_d = tail_q; emitted_d = emitted_q;
    pend_d = pend_q; pend_v_d = pend_v_q; item_d = item_q; vis_d = vis_q;
    outv_d = outv_q && !out_ready_i; outd_d = outd_q;
    adj_we = 1'b0; adj_waddr = '0; adj_wdata = '0;
    adj_raddr = {node_q, idx_q[IW-1:0]};
    // queue appends at tail and pops at head, the stack works at tail - 1
    wk_we = 1'b0; wk_wdata = '0;
    wk_waddr = dfs_q ? VW'(tail_q - PW'(1)) : tail_q[VW-1:0];
    wk_raddr = dfs_q ? VW'(tail_q - PW'(1)) : head_q[VW-1:0];
    deg_we0 = 1'b0; deg_we1 = 1'b0; deg_clr = 1'b0;
    deg_a0 = u; deg_a1 = v; deg_v0 = '0; deg_v1 = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          item_d = in_data_i;
          state_d = S_ADD2;
        end
      end
      S_ADD2: begin
        // decode the held transaction
        if (op_e'(item_q.opcode) == OP_CLEAR) begin
          deg_clr = 1'b1;
          outv_d = 1'b1; outd_d = '{vertex: '0, last: 1'b1, status: ST_OK};
          state_d = S_IDLE;
        end else if (op_e'(item_q.opcode) == OP_ADD) begin
          outv_d = 1'b1;
          outd_d = '{vertex: '0, last: 1'b1, status: ST_OK};
          if (range_bad) outd_d.status = ST_RANGE;
          else if (full_bad) outd_d.status = ST_FULL;
          else begin
            adj_we = 1'b1; adj_waddr = {u, du[IW-1:0]}; adj_wdata = v;
            deg_we0 = 1'b1; deg_v0 = DW'(du + 1);
            if (!item_q.directed) begin
              if (u == v) begin
                // second slot of the self-loop is written next cycle
                deg_v0 = DW'(du + 2);
                node_d = u; idx_d = (IW+1)'(du + 1);
                state_d = S_DONE;
              end else begin
                deg_we1 = 1'b1; deg_v1 = DW'(dv + 1);
                node_d = v; idx_d = (IW+1)'(dv);
                state_d = S_DONE;
              end
            end
          end
          if (state_d == S_ADD2) state_d = S_IDLE;
        end else if (NW'(item_q.start_vertex) >= nv) begin
          outv_d = 1'b1; outd_d = '{vertex: '0, last: 1'b1, status: ST_RANGE};
          state_d = S_IDLE;
        end else begin
          dfs_d = (op_e'(item_q.opcode) == OP_DFS);
          vis_d = '0; vis_d[s] = 1'b1;
          emitted_d = 1'b0;
          head_d = '0; tail_d = PW'(1);
          wk_we = 1'b1; wk_waddr = '0; wk_wdata = {s, {(IW+1){1'b0}}};
          node_d = s; idx_d = '0;
          if (op_e'(item_q.opcode) == OP_DFS) begin
            pend_d = 1'b1; pend_v_d = s;
            state_d = S_NODE;
          end else state_d = S_POP;
        end
      end
      S_DONE: begin
        // second half of an undirected edge: the source goes into the list
        // of node_q at slot idx_q
        adj_we = 1'b1; adj_waddr = {node_q, idx_q[IW-1:0]};
        adj_wdata = u;
        state_d = S_IDLE;
      end
      S_POP: begin
        // bfs: fetch head of queue
        if (head_q == tail_q) state_d = S_OUT;
        else state_d = S_POPRD;
      end
      S_POPRD: begin
        if (!pend_q || out_free) begin
          node_d = wk_node; idx_d = '0;
          head_d = head_q + PW'(1);
          pend_d = 1'b1; pend_v_d = wk_node;
          if (pend_q) begin
            outv_d = 1'b1;
            outd_d = '{vertex: 5'(pend_v_q), last: 1'b0, status: ST_OK};
          end
          state_d = S_NODE;
        end
      end
      S_NODE: begin
        if (idx_q < cur_deg && idx_q < (IW+1)'(MAX_DEGREE)) state_d = S_NBRD;
        else if (dfs_q) begin
          tail_d = tail_q - PW'(1);
          if (tail_q == PW'(1)) state_d = S_OUT;
          else state_d = S_EMIT;
        end else state_d = S_POP;
      end
      S_NBRD: state_d = S_NBCHK;  // adjacency read in flight
      S_NBCHK: begin
        idx_d = idx_q + 1'b1;
        if (!dfs_q) begin
          if (nb_new) begin
            vis_d[nb] = 1'b1;
            wk_we = 1'b1; wk_wdata = {nb, {(IW+1){1'b0}}};
            tail_d = tail_q + PW'(1);
          end
          state_d = S_NODE;
        end else if (nb_new) begin
          if (!pend_q || out_free) begin
            if (pend_q) begin
              outv_d = 1'b1;
              outd_d = '{vertex: 5'(pend_v_q), last: 1'b0, status: ST_OK};
            end
            vis_d[nb] = 1'b1;
            pend_d = 1'b1; pend_v_d = nb;
            // save resume index of current node, push neighbor
            wk_we = 1'b1; wk_waddr = VW'(tail_q - PW'(1));
            wk_wdata = {node_q, idx_q + 1'b1};
            node_d = nb; idx_d = '0;
            tail_d = tail_q + PW'(1);
            state_d = S_NODE;
          end else idx_d = idx_q;
        end else state_d = S_NODE;
      end
      S_EMIT: begin
        // dfs pop: the stack read of the new top address is issued while emitted_q is clear
        state_d = S_EMIT;
        if (emitted_q) begin
          node_d = wk_node; idx_d = wk_idx;
          emitted_d = 1'b0;
          state_d = S_NODE;
        end else emitted_d = 1'b1;
      end
      S_OUT: begin
        if (pend_q && out_free) begin
          outv_d = 1'b1;
          outd_d = '{vertex: 5'(pend_v_q), last: 1'b1, status: ST_OK};
          pend_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      nv_reg_q <= CfgWidth'(32);
      vis_q <= '0;
      outv_q <= 1'b0;
      pend_q <= 1'b0;
      emitted_q <= 1'b0;
      for (int i = 0; i < MAX_VERTICES; i++) deg_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) nv_reg_q <= cfg_wdata_i;
      vis_q <= vis_d;
      outv_q <= outv_d;
      pend_q <= pend_d;
      emitted_q <= emitted_d;
      if (deg_clr) begin
        for (int i = 0; i < MAX_VERTICES; i++) deg_q[i] <= '0;
      end else begin
        if (deg_we0) deg_q[deg_a0] <= deg_v0;
        if (deg_we1) deg_q[deg_a1] <= deg_v1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dfs_q <= dfs_d; node_q <= node_d; idx_q <= idx_d;
    head_q <= head_d; tail_q <= tail_d; pend_v_q <= pend_v_d;
    outd_q <= outd_d; item_q <= item_d;
  end

endmodule

// File: hw/rtl/gbdt_checker.sv
`timescale 1ns / 1ps
module gbdt_checker
  import gbdt_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction taken before result");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status != 2'd3)
    else $error("bad status code");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.last &&
      out_data_o.vertex == '0)
    else $error("error result not final");

endmodule

bind graph_bfs_dfs_traversal gbdt_checker u_gbdt_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
);
